@@ rtl/core/mono_bitmap_pixel_expander_macros.svh @@
// Assertion macros of the bitmap expander, used by its back end
`ifndef MONO_BITMAP_PIXEL_EXPANDER_MACROS_SVH
`define MONO_BITMAP_PIXEL_EXPANDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MBPE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbpe: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MBPE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbpe: assertion failed");

`endif

@@ rtl/core/mbpe_pkg.sv @@
// Types and constants of the monochrome bitmap pixel expander
`default_nettype none

package mbpe_pkg;

	localparam int XY_W    = 8;
	localparam int OFF_W   = 4;
	localparam int CNT_W   = 9;
	localparam int COLOR_W = 16;
	localparam int MODE_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR  = 2'd2;

	localparam logic [COLOR_W-1:0] FG_RESET    = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BG_RESET    = 16'h0000;
	localparam logic [COLOR_W-1:0] COLOR_NONE  = 16'h0000;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_INVERT = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL      = 3'd0,
		MODE_REVERSE     = 3'd1,
		MODE_TRANSPARENT = 3'd2,
		MODE_XOR         = 3'd3,
		MODE_ROTATE      = 3'd4
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0]  draw_mode;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
	} cfg_t;

	// Classified word header handed from the front to the back
	typedef struct packed {
		logic              line_start;
		logic [XY_W-1:0]   start_x;
		logic [XY_W-1:0]   start_y;
		logic [OFF_W-1:0]  start_off;
		logic [OFF_W-1:0]  first_bit;
		logic [CNT_W-1:0]  line_pixels;
	} hdr_t;

endpackage

`default_nettype wire

@@ rtl/core/mbpe_if.sv @@
// Handshake interfaces for bitmap words and pixel operations
`default_nettype none

interface mbpe_in_if #(
	parameter int WORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         line_start;
	logic [mbpe_pkg::XY_W-1:0]    start_x;
	logic [mbpe_pkg::XY_W-1:0]    start_y;
	logic [mbpe_pkg::OFF_W-1:0]   bit_offset;
	logic [mbpe_pkg::CNT_W-1:0]   line_pixels;
	logic [WORD_BITS-1:0]         bitmap_word;

	modport source (
		output valid, line_start, start_x, start_y, bit_offset, line_pixels, bitmap_word,
		input  ready
	);
	modport sink (
		input  valid, line_start, start_x, start_y, bit_offset, line_pixels, bitmap_word,
		output ready
	);
endinterface

interface mbpe_out_if;
	logic                          valid;
	logic                          ready;
	logic                          pixel_op;
	logic [mbpe_pkg::XY_W-1:0]     pixel_x;
	logic [mbpe_pkg::XY_W-1:0]     pixel_y;
	logic [mbpe_pkg::COLOR_W-1:0]  pixel_color;
	logic                          last;

	modport source (
		output valid, pixel_op, pixel_x, pixel_y, pixel_color, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_op, pixel_x, pixel_y, pixel_color, last,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/mono_bitmap_pixel_expander.sv @@
// Expands a line of a one-bit-per-pixel bitmap into pixel write or invert operations.
// Each accepted word is queued (two entries) and then walked by the back end one bit per
// cycle while no pixel waits on the sink: the back end first pops a word, then steps through
// each bit that lies in the active line, and pops the next word only once it is idle. The
// bit walker is the pace setter; bits that produce a pixel also wait for the pixel sink,
// bits that produce nothing step on regardless. Config registers (draw mode, foreground
// and background colors) may be written only while no word is in flight.
`default_nettype none

module mono_bitmap_pixel_expander #(
	parameter int WORD_BITS  = 16,
	parameter int COORD_BITS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	mbpe_in_if.sink                              words,
	mbpe_out_if.source                           pixels,
	input  wire                                  cfg_we,
	input  wire [mbpe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [mbpe_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	mbpe_pkg::cfg_t          cfg_q;
	logic                    q_valid;
	logic                    q_ready;
	mbpe_pkg::hdr_t          q_hdr;
	logic [WORD_BITS-1:0]    q_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.draw_mode <= mbpe_pkg::MODE_NORMAL;
			cfg_q.fg_color  <= mbpe_pkg::FG_RESET;
			cfg_q.bg_color  <= mbpe_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbpe_pkg::REG_DRAW_MODE: cfg_q.draw_mode <= cfg_wdata[mbpe_pkg::MODE_W-1:0];
				mbpe_pkg::REG_FG_COLOR:  cfg_q.fg_color  <= cfg_wdata[mbpe_pkg::COLOR_W-1:0];
				mbpe_pkg::REG_BG_COLOR:  cfg_q.bg_color  <= cfg_wdata[mbpe_pkg::COLOR_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	mbpe_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_hdr   (q_hdr),
		.q_word  (q_word)
	);

	mbpe_back #(
		.WORD_BITS  (WORD_BITS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_hdr   (q_hdr),
		.q_word  (q_word),
		.pixels  (pixels)
	);

endmodule

`default_nettype wire

@@ rtl/core/mbpe_front.sv @@
// Front end: accepts bitmap words, classifies them and queues them
`default_nettype none

module mbpe_front #(
	parameter int WORD_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	mbpe_in_if.sink               words,
	output logic                  q_valid,
	input  wire                   q_ready,
	output mbpe_pkg::hdr_t        q_hdr,
	output logic [WORD_BITS-1:0]  q_word
);

	localparam int DEPTH = 2;

	mbpe_pkg::hdr_t          hdr_q  [DEPTH];
	logic [WORD_BITS-1:0]    word_q [DEPTH];
	logic                    wptr_q;
	logic                    rptr_q;
	logic [1:0]              count_q;

	mbpe_pkg::hdr_t          hdr_new;
	logic                    push;
	logic                    pop;
	logic [5:0]              off_ext;

	always_comb begin
		off_ext = 6'(words.bit_offset);
		hdr_new.line_start  = words.line_start;
		hdr_new.start_x     = words.start_x;
		hdr_new.start_y     = words.start_y;
		hdr_new.start_off   = words.bit_offset;
		hdr_new.line_pixels = words.line_pixels;
		// reduce the offset into the word; it is below twice the word size
		if (off_ext >= 6'(WORD_BITS)) begin
			hdr_new.first_bit = mbpe_pkg::OFF_W'(off_ext - 6'(WORD_BITS));
		end else begin
			hdr_new.first_bit = words.bit_offset;
		end
	end

	assign words.ready = (count_q != 2'(DEPTH));
	assign push        = words.valid && words.ready;
	assign q_valid     = (count_q != 2'd0);
	assign pop         = q_valid && q_ready;
	assign q_hdr       = hdr_q[rptr_q];
	assign q_word      = word_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hdr_q[wptr_q]  <= hdr_new;
			word_q[wptr_q] <= words.bitmap_word;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mbpe_back.sv @@
// Back end: walks the bits of a queued word and issues pixel operations
`default_nettype none
`include "mono_bitmap_pixel_expander_macros.svh"

module mbpe_back #(
	parameter int WORD_BITS  = 16,
	parameter int COORD_BITS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  mbpe_pkg::cfg_t        cfg,
	input  wire                   q_valid,
	output logic                  q_ready,
	input  mbpe_pkg::hdr_t        q_hdr,
	input  wire [WORD_BITS-1:0]   q_word,
	mbpe_out_if.source            pixels
);

	localparam int BP_W  = $clog2(WORD_BITS);
	localparam int END_W = mbpe_pkg::CNT_W + 1;
	localparam logic [BP_W-1:0] LAST_BIT = BP_W'(WORD_BITS - 1);

	// line state
	logic [COORD_BITS-1:0]           cursor_x_q;
	logic [COORD_BITS-1:0]           cursor_y_q;
	logic [BP_W-1:0]                 bitpos_q;
	logic [mbpe_pkg::CNT_W-1:0]      left_q;
	logic                            busy_q;
	// word being walked, indexed from the MSB
	logic [WORD_BITS-1:0]            wbits_q;
	logic [WORD_BITS-1:0]            rem_q;
	// output register
	logic                            out_valid_q;
	logic                            out_op_q;
	logic [mbpe_pkg::XY_W-1:0]       out_x_q;
	logic [mbpe_pkg::XY_W-1:0]       out_y_q;
	logic [mbpe_pkg::COLOR_W-1:0]    out_color_q;
	logic                            out_last_q;

	logic                            emit_clear;
	logic                            rotate;
	logic                            pop;
	logic [BP_W-1:0]                 bp_ld;
	logic [mbpe_pkg::CNT_W-1:0]      left_ld;
	logic [END_W-1:0]                end_v;
	logic [WORD_BITS-1:0]            wbits;
	logic [WORD_BITS-1:0]            mask;
	logic                            cur_set;
	logic                            emit_cur;
	logic                            out_free;
	logic                            advance;
	logic                            step_done;
	logic [WORD_BITS-1:0]            rem_next;
	logic                            op_cur;
	logic [mbpe_pkg::COLOR_W-1:0]    color_cur;
	logic [mbpe_pkg::XY_W:0]         ld_x_sum;

	always_comb begin
		emit_clear = 1'b1;
		rotate     = 1'b0;
		op_cur     = mbpe_pkg::OP_WRITE;
		color_cur  = cur_set ? cfg.fg_color : cfg.bg_color;
		unique case (cfg.draw_mode) inside
			mbpe_pkg::MODE_REVERSE: begin
				color_cur = cur_set ? cfg.bg_color : cfg.fg_color;
			end
			mbpe_pkg::MODE_TRANSPARENT: begin
				emit_clear = 1'b0;
				color_cur  = cfg.fg_color;
			end
			mbpe_pkg::MODE_XOR: begin
				emit_clear = 1'b0;
				op_cur     = mbpe_pkg::OP_INVERT;
				color_cur  = mbpe_pkg::COLOR_NONE;
			end
			mbpe_pkg::MODE_ROTATE: begin
				emit_clear = 1'b0;
				rotate     = 1'b1;
				color_cur  = cfg.fg_color;
			end
			default: begin
				// normal mode, also taken by the unused codes
			end
		endcase
	end

	always_comb begin
		bp_ld   = q_hdr.line_start ? BP_W'(q_hdr.first_bit) : bitpos_q;
		left_ld = q_hdr.line_start ? q_hdr.line_pixels : left_q;
		end_v   = END_W'(bp_ld) + END_W'(left_ld);
		for (int j = 0; j < WORD_BITS; j++) begin
			wbits[j] = q_word[WORD_BITS-1-j];
			mask[j]  = (BP_W'(j) >= bp_ld) && (END_W'(j) < end_v)
				&& (emit_clear || wbits[j]);
		end
	end

	assign ld_x_sum  = (mbpe_pkg::XY_W+1)'(q_hdr.start_x) + (mbpe_pkg::XY_W+1)'(q_hdr.start_off);
	assign q_ready   = !busy_q;
	assign pop       = q_valid && !busy_q;
	assign cur_set   = wbits_q[bitpos_q];
	assign emit_cur  = rem_q[bitpos_q];
	assign out_free  = !out_valid_q || pixels.ready;
	// bits that write nothing step on even while the output is stalled
	assign advance   = busy_q && (out_free || !emit_cur);
	assign step_done = (left_q == mbpe_pkg::CNT_W'(1)) || (bitpos_q == LAST_BIT);
	assign rem_next  = rem_q & ~(WORD_BITS'(1) << bitpos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			bitpos_q    <= '0;
			left_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (q_hdr.line_start) begin
					cursor_x_q <= COORD_BITS'(ld_x_sum);
					cursor_y_q <= COORD_BITS'(q_hdr.start_y);
					bitpos_q   <= bp_ld;
					left_q     <= left_ld;
				end
				busy_q <= (left_ld != '0);
			end
			if (advance) begin
				if (rotate) begin
					cursor_y_q <= cursor_y_q + COORD_BITS'(1);
				end else begin
					cursor_x_q <= cursor_x_q + COORD_BITS'(1);
				end
				left_q   <= left_q - mbpe_pkg::CNT_W'(1);
				bitpos_q <= (bitpos_q == LAST_BIT) ? '0 : bitpos_q + BP_W'(1);
				busy_q   <= !step_done;
			end
			if (advance && emit_cur) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wbits_q <= wbits;
			rem_q   <= mask;
		end else if (advance) begin
			rem_q <= rem_next;
		end
		if (advance && emit_cur) begin
			out_op_q    <= op_cur;
			out_x_q     <= cursor_x_q[mbpe_pkg::XY_W-1:0];
			out_y_q     <= cursor_y_q[mbpe_pkg::XY_W-1:0];
			out_color_q <= color_cur;
			out_last_q  <= (rem_next == '0);
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_op    = out_op_q;
	assign pixels.pixel_x     = out_x_q;
	assign pixels.pixel_y     = out_y_q;
	assign pixels.pixel_color = out_color_q;
	assign pixels.last        = out_last_q;

	`MBPE_ASSERT_IMP(a_busy_has_pixels, clk, arst_n, busy_q, left_q != '0)
	`MBPE_ASSERT_NXT(a_done_goes_idle, clk, arst_n, advance && step_done, !busy_q)
	`MBPE_ASSERT_NXT(a_stall_holds_line, clk, arst_n, busy_q && !advance,
		$stable(cursor_x_q) && $stable(cursor_y_q) && $stable(bitpos_q) && $stable(left_q))
	`MBPE_ASSERT_IMP(a_invert_no_color, clk, arst_n,
		out_valid_q && (out_op_q == mbpe_pkg::OP_INVERT), out_color_q == mbpe_pkg::COLOR_NONE)

endmodule

`default_nettype wire

@@ tb/tb_mono_bitmap_pixel_expander.sv @@
// Self-checking testbench of the monochrome bitmap pixel expander
`default_nettype none

module tb_mono_bitmap_pixel_expander;
	timeunit 1ns;
	timeprecision 1ps;

	import mbpe_pkg::*;

	localparam int WORD_BITS    = 16;
	localparam int COORD_BITS   = 8;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD    = 300;
	localparam int LINES_BUDGET = 10;

	typedef struct packed {
		logic               line_start;
		logic [XY_W-1:0]    start_x;
		logic [XY_W-1:0]    start_y;
		logic [OFF_W-1:0]   bit_offset;
		logic [CNT_W-1:0]   line_pixels;
		logic [WORD_BITS-1:0] bitmap_word;
	} word_t;

	typedef struct packed {
		logic               pixel_op;
		logic [XY_W-1:0]    pixel_x;
		logic [XY_W-1:0]    pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mbpe_in_if #(.WORD_BITS(WORD_BITS)) words_if ();
	mbpe_out_if pixels_if ();

	mono_bitmap_pixel_expander #(
		.WORD_BITS (WORD_BITS),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (words_if),
		.pixels   (pixels_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// shadow registers and line state of the expander
	logic [MODE_W-1:0]  draw_mode_q = MODE_NORMAL;
	logic [COLOR_W-1:0] fg_q = FG_RESET;
	logic [COLOR_W-1:0] bg_q = BG_RESET;
	logic [XY_W-1:0]    cur_x = '0;
	logic [XY_W-1:0]    cur_y = '0;
	logic [OFF_W-1:0]   bit_pos = '0;
	logic [CNT_W-1:0]   pix_left = '0;

	word_t  pending_words[$];
	pixel_t expected_pixels[$];
	int     mismatch_count = 0;
	int     send_idle_pct = 22;
	int     recv_idle_pct = 60;
	bit     word_taken = 1'b0;
	bit     hold_req = 1'b0;
	int     hold_left = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Walk the bits of one word and queue the pixel ops it causes
	task automatic expand_word(input word_t w);
		mode_t  m;
		pixel_t p;
		pixel_t held;
		bit     have_held;
		bit     emit;
		bit     set;
		bit     done;
		m = (draw_mode_q > MODE_ROTATE) ? MODE_NORMAL : mode_t'(draw_mode_q);
		have_held = 1'b0;
		done = 1'b0;
		if (w.line_start) begin
			cur_x = w.start_x + w.bit_offset;
			cur_y = w.start_y;
			bit_pos = w.bit_offset;
			pix_left = w.line_pixels;
		end
		while (pix_left != 0 && !done) begin
			set = w.bitmap_word[WORD_BITS - 1 - int'(bit_pos)];
			emit = 1'b1;
			p.pixel_op = OP_WRITE;
			case (m)
				MODE_REVERSE: begin
					p.pixel_color = set ? bg_q : fg_q;
				end
				MODE_TRANSPARENT, MODE_ROTATE: begin
					emit = set;
					p.pixel_color = fg_q;
				end
				MODE_XOR: begin
					emit = set;
					p.pixel_op = OP_INVERT;
					p.pixel_color = COLOR_NONE;
				end
				default: begin
					p.pixel_color = set ? fg_q : bg_q;
				end
			endcase
			if (emit) begin
				p.pixel_x = cur_x;
				p.pixel_y = cur_y;
				p.last = 1'b0;
				if (have_held)
					expected_pixels.push_back(held);
				held = p;
				have_held = 1'b1;
			end
			if (m == MODE_ROTATE)
				cur_y = cur_y + 1'b1;
			else
				cur_x = cur_x + 1'b1;
			pix_left = pix_left - 1'b1;
			if (bit_pos == WORD_BITS - 1) begin
				bit_pos = '0;
				done = 1'b1;
			end else begin
				bit_pos = bit_pos + 1'b1;
			end
		end
		// flag the final op of this word
		if (have_held) begin
			held.last = 1'b1;
			expected_pixels.push_back(held);
		end
	endtask

	function automatic word_t mk_word(input bit ls, input int sx, input int sy, input int off,
			input int npix, input int bits);
		word_t w;
		w.line_start = ls;
		w.start_x = XY_W'(sx);
		w.start_y = XY_W'(sy);
		w.bit_offset = OFF_W'(off);
		w.line_pixels = CNT_W'(npix);
		w.bitmap_word = WORD_BITS'(bits);
		return w;
	endfunction

	function automatic word_t rand_word(input bit ls);
		return mk_word(ls, $urandom_range(255), $urandom_range(255), $urandom_range(15),
			$urandom_range(511), $urandom_range(16'hFFFF));
	endfunction

	// One line start and its continuation words; sometimes cut short or overrun
	task automatic queue_random_line(inout int budget);
		word_t w;
		int    pick;
		int    n_words;
		int    k;
		w = rand_word(1'b1);
		pick = $urandom_range(9);
		if (pick < 6)
			w.line_pixels = CNT_W'($urandom_range(1, 40));
		else if (pick < 8)
			w.line_pixels = CNT_W'($urandom_range(41, 256));
		else if (pick == 8)
			w.line_pixels = CNT_W'($urandom_range(3));
		n_words = (w.bit_offset + w.line_pixels + WORD_BITS - 1) / WORD_BITS;
		if ($urandom_range(7) == 0)
			n_words = $urandom_range(1, n_words + 2);
		pending_words.push_back(w);
		budget--;
		for (k = 1; k < n_words && budget > 0; k++) begin
			pending_words.push_back(rand_word(1'b0));
			budget--;
		end
		if ($urandom_range(9) == 0 && budget > 0) begin
			pending_words.push_back(rand_word(1'b0));
			budget--;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_DRAW_MODE: draw_mode_q = val[MODE_W-1:0];
			REG_FG_COLOR:  fg_q = val;
			REG_BG_COLOR:  bg_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Upper data bits are don't-care for the mode register; randomize them
	task automatic write_mode(input logic [MODE_W-1:0] m);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[MODE_W-1:0] = m;
		write_reg(REG_DRAW_MODE, d);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_words.size() != 0 || words_if.valid || expected_pixels.size() != 0)
			@(posedge clk);
		// words with no pixels may still be walking
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : drive_words
		word_t nxt;
		if (!arst_n) begin
			words_if.valid <= 1'b0;
		end else if (!words_if.valid || word_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_words.pop_front();
				words_if.valid <= 1'b1;
				words_if.line_start <= nxt.line_start;
				words_if.start_x <= nxt.start_x;
				words_if.start_y <= nxt.start_y;
				words_if.bit_offset <= nxt.bit_offset;
				words_if.line_pixels <= nxt.line_pixels;
				words_if.bitmap_word <= nxt.bitmap_word;
			end else begin
				words_if.valid <= 1'b0;
			end
		end
		word_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pixels_if.ready <= 1'b0;
		end else begin
			pixels_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && pixels_if.valid && pixels_if.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel op at (%0d,%0d)", pixels_if.pixel_x, pixels_if.pixel_y);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixels_if.pixel_op !== want.pixel_op) begin
					$error("pixel_op: expected %0d, got %0d", want.pixel_op, pixels_if.pixel_op);
					mismatch_count++;
				end
				if (pixels_if.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", want.pixel_x, pixels_if.pixel_x);
					mismatch_count++;
				end
				if (pixels_if.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", want.pixel_y, pixels_if.pixel_y);
					mismatch_count++;
				end
				if (pixels_if.pixel_color !== want.pixel_color) begin
					$error("pixel_color: expected %h, got %h", want.pixel_color,
						pixels_if.pixel_color);
					mismatch_count++;
				end
				if (pixels_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, pixels_if.last);
					mismatch_count++;
				end
			end
		end
		if (arst_n && words_if.valid && words_if.ready) begin
			expand_word(mk_word(words_if.line_start, words_if.start_x, words_if.start_y,
				words_if.bit_offset, words_if.line_pixels, words_if.bitmap_word));
			word_taken = 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int s;
		int m;
		int budget;
		logic [MODE_W-1:0] mode_bits;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DRAW_MODE;
		cfg_wdata = '0;
		words_if.valid = 1'b0;
		words_if.line_start = 1'b0;
		words_if.start_x = '0;
		words_if.start_y = '0;
		words_if.bit_offset = '0;
		words_if.line_pixels = '0;
		words_if.bitmap_word = '0;
		pixels_if.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset colors in normal mode
		pending_words.push_back(mk_word(1'b0, 0, 0, 0, 0, 16'hFFFF));     // no line active
		pending_words.push_back(mk_word(1'b1, 0, 0, 0, 0, 16'hFFFF));     // empty line
		pending_words.push_back(mk_word(1'b1, 250, 255, 15, 511, 16'h0001));
		pending_words.push_back(mk_word(1'b0, 0, 0, 0, 0, 16'hFFFF));
		pending_words.push_back(mk_word(1'b0, 255, 255, 15, 511, 16'h0000));
		pending_words.push_back(mk_word(1'b1, 255, 0, 0, 20, 16'h8001)); // restart, x wraps
		pending_words.push_back(mk_word(1'b0, 0, 0, 0, 0, 16'h1234));
		pending_words.push_back(mk_word(1'b0, 0, 0, 0, 0, 16'hFFFF));     // line already done
		pending_words.push_back(mk_word(1'b1, 128, 127, 7, 1, 16'h0100));
		pending_words.push_back(mk_word(1'b1, 0, 255, 0, 256, 16'hA5A5));
		wait_idle();

		// each remaining mode, unused code last; y wraps in rotate
		for (m = int'(MODE_REVERSE); m <= int'(MODE_ROTATE) + 1; m++) begin
			mode_bits = MODE_W'(m);
			write_mode(mode_bits);
			pending_words.push_back(mk_word(1'b1, 250, 250, 4, 24, $urandom_range(16'hFFFF)));
			pending_words.push_back(rand_word(1'b0));
			wait_idle();
		end

		for (s = 0; s < 9; s++) begin
			if (s == 3) begin
				send_idle_pct = 60;
				recv_idle_pct = 22;
			end else if (s == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (s == 8)
				mode_bits = MODE_W'($urandom_range(int'(MODE_ROTATE) + 1, (1 << MODE_W) - 1));
			else
				mode_bits = mode_t'(s % 5);
			write_mode(mode_bits);
			if (s == 0) begin
				write_reg(REG_FG_COLOR, '0);
				write_reg(REG_BG_COLOR, '1);
			end else if (s == 1) begin
				write_reg(REG_FG_COLOR, '1);
				write_reg(REG_BG_COLOR, '0);
			end else begin
				write_reg(REG_FG_COLOR, CFG_DATA_W'($urandom_range(16'hFFFF)));
				write_reg(REG_BG_COLOR, CFG_DATA_W'($urandom_range(16'hFFFF)));
			end
			// hold off the pixel sink so the word queue backs up
			if (s == 0) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			budget = LINES_BUDGET;
			while (budget > 0)
				queue_random_line(budget);
			wait_idle();
		end

		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mbpe_pkg.sv
rtl/core/mbpe_if.sv
rtl/core/mbpe_front.sv
rtl/core/mbpe_back.sv
rtl/core/mono_bitmap_pixel_expander.sv
tb/tb_mono_bitmap_pixel_expander.sv
